// File: rtl/lgsc_pkg.sv
package lgsc_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int SLOT_IDX_W     = 3;
  localparam int PATTERN_ROWS   = 8;
  localparam int SCREEN_ROWS    = 2;
  localparam int SCREEN_COLS    = 16;
  localparam int GLYPH_W        = 64;

  localparam logic [GLYPH_W-1:0] PAT_MASK =
    (PATTERN_ROWS >= 8) ? {GLYPH_W{1'b1}}
                        : ((64'd1 << (8 * PATTERN_ROWS)) - 64'd1);

  typedef enum logic [1:0] {
    CMD_DEFINE = 2'd0,
    CMD_CURSOR = 2'd1,
    CMD_WRITE  = 2'd2
  } lcd_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEFINE,
    ST_CURSOR,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     claim;
    logic     emit;
    lcd_cmd_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go;
    logic miss;
    logic room;
  } dp_stat_t;

endpackage

// File: rtl/lgsc_ctrl.sv
module lgsc_ctrl
  import lgsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.claim   = 1'b0;
    cmd.emit    = 1'b0;
    cmd.op      = CMD_CURSOR;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.go) begin
            cmd.claim  = stat.miss;
            state_next = stat.miss ? ST_DEFINE : ST_CURSOR;
          end
        end
      end
      ST_DEFINE: begin
        cmd.op = CMD_DEFINE;
        if (stat.room) begin
          cmd.emit   = 1'b1;
          state_next = ST_CURSOR;
        end
      end
      ST_CURSOR: begin
        cmd.op = CMD_CURSOR;
        if (stat.room) begin
          cmd.emit   = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.op = CMD_WRITE;
        if (stat.room) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lgsc_dp.sv
module lgsc_dp
  import lgsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cell_row,
  input  logic [3:0]            cell_col,
  input  logic                  cell_dirty,
  input  logic [GLYPH_W-1:0]    glyph_bits,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [1:0]            command,
  output logic [SLOT_IDX_W-1:0] slot_index,
  output logic [GLYPH_W-1:0]    glyph_out,
  output logic                  cursor_row,
  output logic [3:0]            cursor_col,
  output logic                  last_of_run,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat
);

  logic [GLYPH_W-1:0]    slot_pattern [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_used;

  logic [GLYPH_W-1:0]    pat_in;
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_IDX_W-1:0] hit_idx;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic                  hit;
  logic                  has_free;
  logic                  on_screen;

  logic                  cur_row;
  logic [3:0]            cur_col;
  logic [GLYPH_W-1:0]    cur_pat;
  logic [SLOT_IDX_W-1:0] cur_slot;

  assign pat_in    = glyph_bits & PAT_MASK;
  assign on_screen = (32'(cell_row) < 32'(SCREEN_ROWS)) &&
                     (32'(cell_col) < 32'(SCREEN_COLS));

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      match[i] = slot_used[i] && (slot_pattern[i] == pat_in);
      if (match[i]) begin
        hit_idx = SLOT_IDX_W'(i);
      end
      if (!slot_used[i]) begin
        free_idx = SLOT_IDX_W'(i);
      end
    end
    hit      = |match;
    has_free = ~&slot_used;
  end

  assign stat.go   = cell_dirty && on_screen && (hit || has_free);
  assign stat.miss = !hit;
  assign stat.room = !out_valid || !out_stall;

  // slot store
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (cmd.claim && (free_idx == SLOT_IDX_W'(i))) begin
        slot_pattern[i] <= pat_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cmd.claim && (free_idx == SLOT_IDX_W'(i))) begin
          slot_used[i] <= 1'b1;
        end
      end
    end
  end

  // current cell
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_row  <= cell_row;
      cur_col  <= cell_col;
      cur_pat  <= pat_in;
      cur_slot <= hit ? hit_idx : free_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      command <= cmd.op;
      case (cmd.op)
        CMD_DEFINE: begin
          slot_index  <= cur_slot;
          glyph_out   <= cur_pat;
          cursor_row  <= 1'b0;
          cursor_col  <= '0;
          last_of_run <= 1'b0;
        end
        CMD_CURSOR: begin
          slot_index  <= '0;
          glyph_out   <= '0;
          cursor_row  <= cur_row;
          cursor_col  <= cur_col;
          last_of_run <= 1'b0;
        end
        CMD_WRITE: begin
          slot_index  <= cur_slot;
          glyph_out   <= '0;
          cursor_row  <= 1'b0;
          cursor_col  <= '0;
          last_of_run <= 1'b1;
        end
        default: begin
          slot_index  <= '0;
          glyph_out   <= '0;
          cursor_row  <= 1'b0;
          cursor_col  <= '0;
          last_of_run <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/lcd_glyph_slot_cache.sv
// channel | handshake             | fields
// in      | in_valid / in_stall   | cell_row cell_col cell_dirty glyph_bits
// out     | out_valid / out_stall | command slot_index glyph_out cursor_row
//         |                       | cursor_col last_of_run
//
// a clean, off-screen or uncacheable cell is only accepted; a slot hit then issues
// cursor and write, a miss define, cursor and write (one per state, as room allows)
// the slot compare runs against all slots in the accept cycle
// reset clears every slot's used flag and the output valid flag
// out_stall holds the sequencer; a new cell is taken while the last command waits
module lcd_glyph_slot_cache
  import lgsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cell_row,
  input  logic [3:0]            cell_col,
  input  logic                  cell_dirty,
  input  logic [GLYPH_W-1:0]    glyph_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            command,
  output logic [SLOT_IDX_W-1:0] slot_index,
  output logic [GLYPH_W-1:0]    glyph_out,
  output logic                  cursor_row,
  output logic [3:0]            cursor_col,
  output logic                  last_of_run
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lgsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lgsc_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_dirty  (cell_dirty),
    .glyph_bits  (glyph_bits),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .command     (command),
    .slot_index  (slot_index),
    .glyph_out   (glyph_out),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col),
    .last_of_run (last_of_run),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// File: rtl/lgsc_checker.sv
module lgsc_checker
  import lgsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  cell_dirty,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            command,
  input logic [SLOT_IDX_W-1:0] slot_index,
  input logic [GLYPH_W-1:0]    glyph_out,
  input logic                  cursor_row,
  input logic [3:0]            cursor_col,
  input logic                  last_of_run
);

  // held item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({command, slot_index, glyph_out, cursor_row, cursor_col, last_of_run}))
    else $error("stalled output item changed");

  // clean cell leaves the block free
  a_clean_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !cell_dirty |=> !in_stall)
    else $error("clean cell held the input");

  // after a define, cursor and write are still pending
  a_define_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (command == CMD_DEFINE) |=> in_stall)
    else $error("input open right after define");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lcd_glyph_slot_cache lgsc_checker u_lgsc_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lgsc_pkg::*;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_HIT, CHK_MISS} chk_t;

  typedef struct {
    logic                  row;
    logic [3:0]            col;
    logic                  dirty;
    logic [GLYPH_W-1:0]    glyph;
    chk_t                  chk;
    logic [SLOT_IDX_W-1:0] slot;
  } cell_t;

  typedef struct {
    lcd_cmd_t              cmd;
    logic [SLOT_IDX_W-1:0] slot;
    logic [GLYPH_W-1:0]    glyph;
    logic                  row;
    logic [3:0]            col;
    logic                  last;
  } lcd_op_t;

  localparam int N_CELLS = 220;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  cell_row;
  logic [3:0]            cell_col;
  logic                  cell_dirty;
  logic [GLYPH_W-1:0]    glyph_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            command;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [GLYPH_W-1:0]    glyph_out;
  logic                  cursor_row;
  logic [3:0]            cursor_col;
  logic                  last_of_run;

  lcd_op_t            pending_ops[$];
  cell_t              directed_cells[$];
  logic [GLYPH_W-1:0] slot_pat[SLOT_COUNT_DEF];
  logic               slot_taken[SLOT_COUNT_DEF];
  int                 mismatches = 0;

  lcd_glyph_slot_cache dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .cell_dirty (cell_dirty),
    .glyph_bits (glyph_bits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .slot_index (slot_index),
    .glyph_out  (glyph_out),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  function automatic lcd_op_t mk_op(lcd_cmd_t cmd, logic [SLOT_IDX_W-1:0] slot,
                                    logic [GLYPH_W-1:0] glyph, logic row,
                                    logic [3:0] col, logic last);
    lcd_op_t op;
    op.cmd   = cmd;
    op.slot  = slot;
    op.glyph = glyph;
    op.row   = row;
    op.col   = col;
    op.last  = last;
    return op;
  endfunction

  function automatic cell_t mk_cell(logic row, logic [3:0] col, logic dirty,
                                    logic [GLYPH_W-1:0] glyph, chk_t chk,
                                    logic [SLOT_IDX_W-1:0] slot);
    cell_t c;
    c.row   = row;
    c.col   = col;
    c.dirty = dirty;
    c.glyph = glyph;
    c.chk   = chk;
    c.slot  = slot;
    return c;
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  // updates the model slot store, queues the expected commands when keep is set and returns their count
  function automatic int predict_cell(cell_t c, bit keep);
    logic [GLYPH_W-1:0] pat;
    int                 hit;
    lcd_op_t            ops[$];
    pat = c.glyph & PAT_MASK;
    hit = -1;
    if (!c.dirty || c.row >= SCREEN_ROWS || c.col >= SCREEN_COLS) return 0;
    for (int i = 0; i < SLOT_COUNT_DEF; i++)
      if (hit < 0 && slot_taken[i] && slot_pat[i] == pat) hit = i;
    if (hit < 0) begin
      for (int i = 0; i < SLOT_COUNT_DEF; i++)
        if (hit < 0 && !slot_taken[i]) hit = i;
      if (hit < 0) return 0;
      slot_taken[hit] = 1'b1;
      slot_pat[hit]   = pat;
      ops.push_back(mk_op(CMD_DEFINE, hit[SLOT_IDX_W-1:0], pat, 1'b0, 4'd0, 1'b0));
    end
    ops.push_back(mk_op(CMD_CURSOR, '0, '0, c.row, c.col, 1'b0));
    ops.push_back(mk_op(CMD_WRITE, hit[SLOT_IDX_W-1:0], '0, 1'b0, 4'd0, 1'b1));
    if (keep) foreach (ops[k]) pending_ops.push_back(ops[k]);
    return ops.size();
  endfunction

  // mostly hits on stored patterns, then clean cells and unknown patterns
  function automatic cell_t random_cell();
    cell_t c;
    int    sel;
    int    idx;
    sel = $urandom_range(0, 99);
    idx = $urandom_range(0, SLOT_COUNT_DEF - 1);
    c = mk_cell(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b1,
                {$urandom, $urandom}, CHK_MODEL, '0);
    if (sel < 60) begin
      if (slot_taken[idx]) c.glyph = slot_pat[idx];
    end else if (sel < 78) begin
      c.dirty = 1'b0;
    end
    return c;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    lcd_op_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ops.size() == 0) begin
        $display("%0t unexpected item: expected none actual command %0h slot %0h",
                 $time, command, slot_index);
        mismatches++;
      end else begin
        want = pending_ops.pop_front();
        check_field("command", 64'(want.cmd), 64'(command));
        check_field("slot_index", 64'(want.slot), 64'(slot_index));
        check_field("glyph_out", want.glyph, glyph_out);
        check_field("cursor_row", 64'(want.row), 64'(cursor_row));
        check_field("cursor_col", 64'(want.col), 64'(cursor_col));
        check_field("last_of_run", 64'(want.last), 64'(last_of_run));
      end
    end
  end

  initial begin
    int hold;
    int n_res;
    n_res     = 0;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = draw_wait((n_res / 25) % 3 == 2);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_res++;
    end
  end

  initial begin
    cell_t cur;
    int    i;
    int    gap;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cell_row   = 1'b0;
    cell_col   = 4'd0;
    cell_dirty = 1'b0;
    glyph_bits = '0;
    for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
      slot_taken[s] = 1'b0;
      slot_pat[s]   = '0;
    end

    directed_cells.push_back(mk_cell(1'b0, 4'd0,  1'b0, '1, CHK_NONE, '0));
    directed_cells.push_back(mk_cell(1'b0, 4'd0,  1'b1, '0, CHK_MISS, 3'd0));
    directed_cells.push_back(mk_cell(1'b1, 4'd15, 1'b1, '1, CHK_MISS, 3'd1));
    directed_cells.push_back(mk_cell(1'b1, 4'd15, 1'b1, '0, CHK_HIT,  3'd0));
    directed_cells.push_back(mk_cell(1'b1, 4'd15, 1'b0, '0, CHK_NONE, '0));
    directed_cells.push_back(mk_cell(1'b0, 4'd7,  1'b1, '1, CHK_HIT,  3'd1));
    directed_cells.push_back(mk_cell(1'b0, 4'd1, 1'b1, 64'h0123_4567_89AB_CDEF, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd2, 1'b1, 64'h8000_0000_0000_0000, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b0, 4'd3, 1'b1, 64'h0000_0000_0000_0001, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd4, 1'b1, 64'hAA55_AA55_AA55_AA55, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b0, 4'd8, 1'b1, 64'h55AA_55AA_55AA_55AA, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd9, 1'b1, 64'hFEDC_BA98_7654_3210, CHK_MODEL, '0));
    // store is full from here on, unknown patterns are dropped
    directed_cells.push_back(mk_cell(1'b0, 4'd5,  1'b1, 64'h7FFF_FFFF_FFFF_FFFE, CHK_NONE, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd15, 1'b1, 64'h0000_0001_0000_0000, CHK_NONE, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd6, 1'b1, 64'hFEDC_BA98_7654_3210, CHK_MODEL, '0));
    directed_cells.push_back(mk_cell(1'b0, 4'd10, 1'b0, 64'h1357_9BDF_0246_8ACE, CHK_NONE, '0));
    directed_cells.push_back(mk_cell(1'b1, 4'd0,  1'b1, '1, CHK_HIT, 3'd1));
    directed_cells.push_back(mk_cell(1'b0, 4'd15, 1'b1, '0, CHK_HIT, 3'd0));
    directed_cells.push_back(mk_cell(1'b1, 4'd11, 1'b1, 64'h0123_4567_89AB_CDEF, CHK_MODEL, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    i = 0;
    while (i < N_CELLS) begin
      if (i < directed_cells.size()) cur = directed_cells[i];
      else cur = random_cell();
      gap = draw_wait((i / 30) % 3 == 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      cell_row   <= cur.row;
      cell_col   <= cur.col;
      cell_dirty <= cur.dirty;
      glyph_bits <= cur.glyph;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      void'(predict_cell(cur, cur.chk == CHK_MODEL));
      if (cur.chk == CHK_MISS)
        pending_ops.push_back(mk_op(CMD_DEFINE, cur.slot, cur.glyph & PAT_MASK,
                                    1'b0, 4'd0, 1'b0));
      if (cur.chk == CHK_HIT || cur.chk == CHK_MISS) begin
        pending_ops.push_back(mk_op(CMD_CURSOR, '0, '0, cur.row, cur.col, 1'b0));
        pending_ops.push_back(mk_op(CMD_WRITE, cur.slot, '0, 1'b0, 4'd0, 1'b1));
      end
      i++;
    end
    in_valid <= 1'b0;

    while (pending_ops.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("[lcd_glyph_slot_cache] OK");
    else
      $display("[lcd_glyph_slot_cache] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[lcd_glyph_slot_cache] ERROR");
    $finish;
  end

endmodule
